FILE: rtl/core/assert_macros.svh
// assertion macros shared by the core rtl
// no dependencies; every macro takes its clock and active-low reset
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define ASSERT_CLKD(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);

// expression must never be true outside reset
`define ASSERT_NEVER(lbl, clk, rst_n, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) !(expr)) else $error(msg);

`endif

FILE: rtl/core/ddvr_pkg.sv
// shared types and constants of the differential drive velocity ramp core
// no dependencies; used by the interfaces, controller, datapath and top level
package ddvr_pkg;

    localparam int REG_W     = 16;
    localparam int CMD_W     = 16;
    localparam int CFG_IDX_W = 3;
    localparam int HI_W      = 31;
    localparam int LO_W      = 32;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_LEFT_GAIN      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RIGHT_GAIN     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HALF_SEP       = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_STEP_THRESHOLD = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_VELOCITY_SCALE = 3'd4;

    // configuration reset values
    localparam logic [REG_W-1:0] LEFT_GAIN_RST      = 16'd2560;
    localparam logic [REG_W-1:0] RIGHT_GAIN_RST     = 16'd2560;
    localparam logic [REG_W-1:0] HALF_SEP_RST       = 16'd64;
    localparam logic [REG_W-1:0] STEP_THRESHOLD_RST = 16'd77;
    localparam logic [REG_W-1:0] VELOCITY_SCALE_RST = 16'd6679;

    typedef enum logic [1:0] {
        MODE_SINGLE = 2'd0,
        MODE_UP     = 2'd1,
        MODE_DOWN   = 2'd2
    } t_mode;

    typedef enum logic [9:0] {
        S_IDLE = 10'b0000000001,
        S_WS   = 10'b0000000010,
        S_BASE = 10'b0000000100,
        S_MUL1 = 10'b0000001000,
        S_MUL2 = 10'b0000010000,
        S_DIV  = 10'b0000100000,
        S_REM  = 10'b0001000000,
        S_SAVE = 10'b0010000000,
        S_INIT = 10'b0100000000,
        S_EMIT = 10'b1000000000
    } t_state;

    typedef struct packed {
        logic load;
        logic ws_en;
        logic base_en;
        logic mul1_en;
        logic mul2_en;
        logic div_en;
        logic rem_en;
        logic save_en;
        logic init_en;
        logic step_en;
        logic sel;
    } t_dp_cmd;

    typedef struct packed {
        t_mode mode;
    } t_dp_sts;

endpackage

FILE: rtl/core/ddvr_in_if.sv
// valid/ready channel carrying one speed target
// depends on ddvr_pkg
interface ddvr_in_if;
    import ddvr_pkg::*;

    logic                    valid;
    logic                    ready;
    logic signed [CMD_W-1:0] target_linear;
    logic signed [CMD_W-1:0] target_angular;

    modport source(output valid, output target_linear, output target_angular, input ready);
    modport sink(input valid, input target_linear, input target_angular, output ready);
endinterface

FILE: rtl/core/ddvr_out_if.sv
// valid/ready channel carrying one pair of wheel commands
// depends on ddvr_pkg
interface ddvr_out_if;
    import ddvr_pkg::*;

    logic                    valid;
    logic                    ready;
    logic signed [CMD_W-1:0] left_command;
    logic signed [CMD_W-1:0] right_command;
    logic                    last_of_run;

    modport source(output valid, output left_command, output right_command,
                   output last_of_run, input ready);
    modport sink(input valid, input left_command, input right_command,
                 input last_of_run, output ready);
endinterface

FILE: rtl/core/ddvr_ctrl.sv
// sequencing state machine of the velocity ramp core
// depends on ddvr_pkg and assert_macros.svh
`include "assert_macros.svh"

module ddvr_ctrl #(
    parameter int RAMP_STEPS = 30
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic              o_last,
    output ddvr_pkg::t_dp_cmd o_cmd,
    input  ddvr_pkg::t_dp_sts i_sts
);
    import ddvr_pkg::*;

    localparam int CW = $clog2(RAMP_STEPS + 2);

    t_state               r_state, n_state;
    logic                 r_sel, n_sel;
    logic [CW-1:0]        r_cnt, n_cnt;
    t_dp_cmd              cmd;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = (r_state == S_EMIT);
    assign o_last      = (r_cnt == CW'(1));
    assign o_cmd       = cmd;

    always_comb begin
        n_state   = r_state;
        n_sel     = r_sel;
        n_cnt     = r_cnt;
        cmd       = '0;
        cmd.sel   = r_sel;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    cmd.load = 1'b1;
                    n_sel    = 1'b0;
                    n_state  = S_WS;
                end
            end
            S_WS: begin
                cmd.ws_en = 1'b1;
                n_state   = S_BASE;
            end
            S_BASE: begin
                cmd.base_en = 1'b1;
                n_state     = S_MUL1;
            end
            S_MUL1: begin
                cmd.mul1_en = 1'b1;
                n_state     = S_MUL2;
            end
            S_MUL2: begin
                cmd.mul2_en = 1'b1;
                if (i_sts.mode != MODE_SINGLE) begin
                    n_state = S_DIV;
                end else if (!r_sel) begin
                    n_sel   = 1'b1;
                    n_state = S_BASE;
                end else begin
                    n_state = S_INIT;
                end
            end
            S_DIV: begin
                cmd.div_en = 1'b1;
                n_state    = S_REM;
            end
            S_REM: begin
                cmd.rem_en = 1'b1;
                n_state    = S_SAVE;
            end
            S_SAVE: begin
                cmd.save_en = 1'b1;
                if (!r_sel) begin
                    n_sel   = 1'b1;
                    n_state = S_BASE;
                end else begin
                    n_state = S_INIT;
                end
            end
            S_INIT: begin
                cmd.init_en = 1'b1;
                case (i_sts.mode)
                    MODE_UP:   n_cnt = CW'(RAMP_STEPS);
                    MODE_DOWN: n_cnt = CW'(RAMP_STEPS + 1);
                    default:   n_cnt = CW'(1);
                endcase
                n_state = S_EMIT;
            end
            S_EMIT: begin
                if (i_out_ready) begin
                    if (o_last) begin
                        n_state = S_IDLE;
                    end else begin
                        cmd.step_en = 1'b1;
                        n_cnt       = r_cnt - 1'b1;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_sel     <= 1'b0;
            r_cnt     <= '0;
        end else begin
            r_state   <= n_state;
            r_sel     <= n_sel;
            r_cnt     <= n_cnt;
        end
    end

    `ASSERT_CLKD(a_last_frees_input, i_clk, i_rst_n, (o_out_valid && i_out_ready && o_last) |=> o_in_ready, "input not freed after final transfer")
    `ASSERT_CLKD(a_save_follows_div, i_clk, i_rst_n, (r_state == S_SAVE) |-> $past(r_state == S_REM), "quotient saved without division")
    `ASSERT_NEVER(a_emit_without_count, i_clk, i_rst_n, (r_state == S_EMIT) && (r_cnt == '0), "result offered with empty run count")
    `ASSERT_NEVER(a_in_and_out_overlap, i_clk, i_rst_n, o_in_ready && o_out_valid, "input taken while results pending")

endmodule

FILE: rtl/core/ddvr_datapath.sv
// arithmetic of the velocity ramp core: config, wheel products, divider, ramp steps
// depends on ddvr_pkg
module ddvr_datapath #(
    parameter int RAMP_STEPS = 30
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [ddvr_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [ddvr_pkg::REG_W-1:0]         i_cfg_data,
    input  logic signed [ddvr_pkg::CMD_W-1:0]  i_target_linear,
    input  logic signed [ddvr_pkg::CMD_W-1:0]  i_target_angular,
    input  ddvr_pkg::t_dp_cmd                  i_cmd,
    output ddvr_pkg::t_dp_sts                  o_sts,
    output logic signed [ddvr_pkg::CMD_W-1:0]  o_left_command,
    output logic signed [ddvr_pkg::CMD_W-1:0]  o_right_command
);
    import ddvr_pkg::*;

    localparam int NW = $clog2(RAMP_STEPS + 1);
    localparam int RW = NW + LO_W;
    localparam logic [NW-1:0] N_DIV  = NW'(RAMP_STEPS);
    localparam logic [RW-1:0] D_FULL = {N_DIV, {LO_W{1'b0}}};
    // floor(2^32 / step count); the estimate is at most one below the true quotient
    localparam logic [LO_W:0] RECIP  = 33'((64'd1 << LO_W) / 64'(RAMP_STEPS));

    // configuration
    logic [REG_W-1:0] r_left_gain, r_right_gain, r_half_sep, r_thr, r_vs;

    // per item
    logic [15:0]      r_prev, r_lin, r_w;
    t_mode            r_mode;
    logic [31:0]      r_ws;
    logic [31:0]      r_mb;
    logic [15:0]      r_mg;
    logic             r_neg;
    logic [47:0]      r_p1;
    logic [HI_W-1:0]  r_dvd;
    logic [HI_W-1:0]  r_qe;
    logic [NW:0]      r_rem;

    // per wheel
    logic [HI_W-1:0]  r_hi [2];
    logic [LO_W-1:0]  r_lo [2];
    logic             r_wneg [2];
    logic [HI_W-1:0]  r_qa [2];
    logic [RW-1:0]    r_ra [2];
    logic [HI_W-1:0]  r_q [2];
    logic [RW-1:0]    r_r [2];

    logic [16:0]      diff, adiff;
    logic             ramp, prev_zero;
    logic signed [32:0] ws_full;
    logic [32:0]      lin_ext, ws_ext, base, base_mag;
    logic [15:0]      gain;
    logic [16:0]      gain_mag;
    logic [47:0]      p1_full;
    logic [63:0]      a_full;
    logic [63:0]      recip_prod;
    logic [HI_W-1:0]  qn;
    logic [HI_W-1:0]  rem_full;
    logic             fix;
    logic [HI_W-1:0]  qa_fix;
    logic [NW-1:0]    rem_fix;
    logic [RW-1:0]    lo_n [2];
    logic [RW:0]      r_up [2];
    logic [RW:0]      r_dn [2];

    function automatic logic [15:0] sat_cmd(input logic [HI_W-1:0] mag, input logic neg);
        logic [15:0] m;
        m = mag[15:0];
        if (neg) begin
            return (mag > HI_W'(32768)) ? 16'h8000 : (16'd0 - m);
        end
        return (mag > HI_W'(32767)) ? 16'h7fff : m;
    endfunction

    assign o_sts.mode      = r_mode;
    assign o_left_command  = $signed(sat_cmd(r_q[0], r_wneg[0]));
    assign o_right_command = $signed(sat_cmd(r_q[1], r_wneg[1]));

    // ramp decision on the incoming target
    always_comb begin
        diff      = {i_target_linear[15], i_target_linear} - {r_prev[15], r_prev};
        adiff     = diff[16] ? (17'd0 - diff) : diff;
        ramp      = (adiff >= {1'b0, r_thr});
        prev_zero = (r_prev == 16'd0);
    end

    // wheel base speed in q16.16, split into sign and magnitude
    always_comb begin
        ws_full  = $signed(r_w) * $signed({1'b0, r_half_sep});
        lin_ext  = {{9{r_lin[15]}}, r_lin, 8'd0};
        ws_ext   = {r_ws[31], r_ws};
        base     = i_cmd.sel ? (lin_ext + ws_ext) : (lin_ext - ws_ext);
        base_mag = base[32] ? (33'd0 - base) : base;
        gain     = i_cmd.sel ? r_right_gain : r_left_gain;
        gain_mag = gain[15] ? (17'd0 - {1'b1, gain}) : {1'b0, gain};
        p1_full  = r_mb * r_mg;
        a_full   = r_p1 * r_vs;
    end

    // high product word over the step count: reciprocal estimate, remainder, one fix-up
    always_comb begin
        recip_prod = {33'd0, r_dvd} * {31'd0, RECIP};
        qn         = r_qe * HI_W'(N_DIV);
        rem_full   = r_dvd - qn;
        fix        = (r_rem >= {1'b0, N_DIV});
        qa_fix     = fix ? (r_qe + 1'b1) : r_qe;
        rem_fix    = fix ? NW'(r_rem - {1'b0, N_DIV}) : r_rem[NW-1:0];
    end

    always_comb begin
        for (int i = 0; i < 2; i++) begin
            lo_n[i] = {{NW{1'b0}}, r_lo[i]} * RW'(N_DIV);
            r_up[i] = {1'b0, r_r[i]} + {1'b0, r_ra[i]};
            r_dn[i] = {1'b0, r_r[i]} - {1'b0, r_ra[i]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left_gain  <= LEFT_GAIN_RST;
            r_right_gain <= RIGHT_GAIN_RST;
            r_half_sep   <= HALF_SEP_RST;
            r_thr        <= STEP_THRESHOLD_RST;
            r_vs         <= VELOCITY_SCALE_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_LEFT_GAIN:      r_left_gain  <= i_cfg_data;
                CFG_RIGHT_GAIN:     r_right_gain <= i_cfg_data;
                CFG_HALF_SEP:       r_half_sep   <= i_cfg_data;
                CFG_STEP_THRESHOLD: r_thr        <= i_cfg_data;
                CFG_VELOCITY_SCALE: r_vs         <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev <= '0;
            r_mode <= MODE_SINGLE;
        end else if (i_cmd.load) begin
            r_prev <= i_target_linear;
            if (!ramp) begin
                r_mode <= MODE_SINGLE;
            end else if (prev_zero) begin
                r_mode <= MODE_UP;
            end else begin
                r_mode <= MODE_DOWN;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_lin <= (ramp && !prev_zero) ? r_prev : i_target_linear;
            r_w   <= i_target_angular;
        end
        if (i_cmd.ws_en) begin
            r_ws <= ws_full[31:0];
        end
        if (i_cmd.base_en) begin
            r_mb  <= base_mag[31:0];
            r_mg  <= gain_mag[15:0];
            r_neg <= base[32] ^ gain[15];
        end
        if (i_cmd.mul1_en) begin
            r_p1 <= p1_full;
        end
        if (i_cmd.mul2_en) begin
            r_hi[i_cmd.sel]   <= a_full[62:32];
            r_lo[i_cmd.sel]   <= a_full[31:0];
            r_wneg[i_cmd.sel] <= r_neg;
            r_dvd             <= a_full[62:32];
        end
        if (i_cmd.div_en) begin
            r_qe <= recip_prod[LO_W +: HI_W];
        end
        if (i_cmd.rem_en) begin
            r_rem <= rem_full[NW:0];
        end
        if (i_cmd.save_en) begin
            r_qa[i_cmd.sel] <= qa_fix;
            r_ra[i_cmd.sel] <= {rem_fix, r_lo[i_cmd.sel]};
        end
        for (int i = 0; i < 2; i++) begin
            if (i_cmd.init_en) begin
                case (r_mode)
                    MODE_UP: begin
                        r_q[i] <= r_qa[i];
                        r_r[i] <= r_ra[i];
                    end
                    MODE_DOWN: begin
                        r_q[i] <= r_hi[i];
                        r_r[i] <= lo_n[i];
                    end
                    default: begin
                        r_q[i] <= r_hi[i];
                        r_r[i] <= '0;
                    end
                endcase
            end else if (i_cmd.step_en) begin
                if (r_mode == MODE_DOWN) begin
                    if (r_dn[i][RW]) begin
                        r_q[i] <= r_q[i] - r_qa[i] - 1'b1;
                        r_r[i] <= r_dn[i][RW-1:0] + D_FULL;
                    end else begin
                        r_q[i] <= r_q[i] - r_qa[i];
                        r_r[i] <= r_dn[i][RW-1:0];
                    end
                end else begin
                    if (r_up[i] >= {1'b0, D_FULL}) begin
                        r_q[i] <= r_q[i] + r_qa[i] + 1'b1;
                        r_r[i] <= RW'(r_up[i] - {1'b0, D_FULL});
                    end else begin
                        r_q[i] <= r_q[i] + r_qa[i];
                        r_r[i] <= r_up[i][RW-1:0];
                    end
                end
            end
        end
    end

endmodule

FILE: rtl/core/diff_drive_velocity_ramp_core.sv
// top level of the differential drive velocity ramp core
// depends on ddvr_pkg, ddvr_in_if, ddvr_out_if, ddvr_ctrl and ddvr_datapath
//
// usage
//   i_in carries one target (linear and angular speed, signed q8.8) per transfer.
//   o_out carries wheel command pairs (saturated int16); last_of_run marks the
//   final pair caused by a target. a target gives one pair, a ramp up of
//   RAMP_STEPS pairs (from rest) or a ramp down of RAMP_STEPS+1 pairs to zero.
//   configuration goes through i_cfg_we / i_cfg_idx / i_cfg_data, one register
//   per write, and is meant to change only while the core is idle.
// sequencing and throughput
//   one target at a time; i_in.ready is high only when idle.
//   single command: after the input transfer, ws, then base, mul1 and mul2 per
//   wheel, then init; the first pair is valid in emit. ramp: each wheel also takes
//   a reciprocal multiply, a remainder and a fix-up step to divide its product by
//   RAMP_STEPS before init.
//   after that the pairs come one per cycle while o_out is ready, each step a
//   remainder add or subtract and compare.
// reset
//   synchronous active-low reset loads register defaults and clears the
//   previous speed to zero.
// stall
//   a stalled o_out holds the current pair; nothing is lost or repeated.
module diff_drive_velocity_ramp_core #(
    parameter int RAMP_STEPS = 30
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [ddvr_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [ddvr_pkg::REG_W-1:0]     i_cfg_data,
    ddvr_in_if.sink                        i_in,
    ddvr_out_if.source                     o_out
);
    import ddvr_pkg::*;

    // controller to datapath commands and status back
    t_dp_cmd dp_cmd;
    t_dp_sts dp_sts;
    logic    in_ready;

    assign i_in.ready = in_ready;

    // sequencer: accepts a target, walks both wheels, then emits the run
    ddvr_ctrl #(
        .RAMP_STEPS (RAMP_STEPS)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (in_ready),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .o_last      (o_out.last_of_run),
        .o_cmd       (dp_cmd),
        .i_sts       (dp_sts)
    );

    // arithmetic: products, division by step count, ramp accumulation
    ddvr_datapath #(
        .RAMP_STEPS (RAMP_STEPS)
    ) u_datapath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_idx        (i_cfg_idx),
        .i_cfg_data       (i_cfg_data),
        .i_target_linear  (i_in.target_linear),
        .i_target_angular (i_in.target_angular),
        .i_cmd            (dp_cmd),
        .o_sts            (dp_sts),
        .o_left_command   (o_out.left_command),
        .o_right_command  (o_out.right_command)
    );

endmodule
